@@ rtl/core/sge_pkg.sv @@
// sge_pkg: shared types and constants of the grid epidemic step block
// holds transaction payload structs, cell word layout, state and code enums
// no dependencies
`timescale 1ns / 1ps

package sge_pkg;

  // fixed point layout of the fractions
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_W     = FRAC_BITS + 1;
  localparam int POP_W      = 20;
  localparam int NEIGHBOURS = 8;
  localparam int DIR_W      = 3;
  // neighbour sum: eight terms of at most one
  localparam int SUM_W      = FRAC_W + DIR_W;
  localparam int PROD_W     = 2 * FRAC_W;
  localparam int TOT_W      = 32;

  localparam logic [FRAC_W-1:0] ONE = FRAC_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    ACT_LOAD_CELL   = 2'd0,
    ACT_LOAD_TRAVEL = 2'd1,
    ACT_STEP        = 2'd2,
    ACT_NONE        = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_ROWS      = 2'd0,
    REG_COLS      = 2'd1,
    REG_VIRULENCE = 2'd2,
    REG_RECOVERY  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_CELL  = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [5:0]        row;
    logic [5:0]        col;
    logic [POP_W-1:0]  population;
    logic [FRAC_W-1:0] infected_share;
    logic [DIR_W-1:0]  neighbour;
    logic [FRAC_W-1:0] travel_prob;
  } in_t;

  typedef struct packed {
    logic [TOT_W-1:0] total_infected;
    logic [TOT_W-1:0] total_susceptible;
    logic [TOT_W-1:0] total_removed;
    logic [TOT_W-1:0] generation;
  } out_t;

  // one entry of the cell store
  typedef struct packed {
    logic [POP_W-1:0]  pop;
    logic [FRAC_W-1:0] s;
    logic [FRAC_W-1:0] i;
    logic [FRAC_W-1:0] r;
  } cell_word_t;

  typedef logic [NEIGHBOURS-1:0][FRAC_W-1:0] travel_row_t;

  // stage strobes from the sequencer to the update datapath
  typedef struct packed {
    logic mul_rate;
    logic mul_inf;
    logic hold_new;
    logic mul_wt;
  } upd_ctl_t;

  function automatic logic [FRAC_W-1:0] clamp_one(input logic [FRAC_W-1:0] x);
    clamp_one = (x > ONE) ? ONE : x;
  endfunction

endpackage

@@ rtl/core/sir_grid_epidemic_step_top.sv @@
// A step walks over all MAX_ROWS*MAX_COLS cells, with a full update for each cell inside
// the active grid and a plain copy for each cell outside it, then posts the result.
// The single read port of the cell store shapes the update: each active cell reads itself
// and its eight neighbours one after another. Loads are taken one item at a time.
// After reset a clearing pass over all MAX_ROWS*MAX_COLS cells runs before items are
// accepted; configuration writes are accepted at all times.
// top level: sequencer, ping-pong cell store, travel store, totals
// depends on sge_pkg and sge_cell_update
`timescale 1ns / 1ps

module sir_grid_epidemic_step_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  sge_pkg::in_t               item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output sge_pkg::out_t              result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [sge_pkg::FRAC_W-1:0] cfg_data
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DIM_W  = 11;
  localparam int FW     = sge_pkg::FRAC_W;
  localparam int FB     = sge_pkg::FRAC_BITS;
  localparam int PW     = sge_pkg::POP_W;
  localparam int SW     = sge_pkg::SUM_W;
  localparam int ACC_W  = (PW + CELL_W + 1 > 33) ? PW + CELL_W + 1 : 33;
  localparam int PH_W   = 4;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(14);

  sge_pkg::state_t      state, state_next;
  logic [PH_W-1:0]      ph;
  logic [CELL_W-1:0]    cell_idx;
  logic [ROW_W-1:0]     r_cnt;
  logic [COL_W-1:0]     c_cnt;
  logic                 bank;
  logic [31:0]          generation;
  logic [6:0]           grid_rows, grid_cols;
  logic                 rows_full, cols_full;
  logic [FW-1:0]        virulence, recovery_rate;
  logic [DIM_W-1:0]     rows_eff, cols_eff;

  // memories and their ports
  sge_pkg::cell_word_t  cell_mem [2][CELLS];
  sge_pkg::travel_row_t travel_mem [CELLS];
  logic                 cm_we, cm_wbank;
  logic [CELL_W-1:0]    cm_waddr, cm_raddr;
  sge_pkg::cell_word_t  cm_wdata, cm_rdata;
  logic                 tm_clr, tm_we;
  logic [CELL_W-1:0]    tm_waddr;
  logic [2:0]           tm_lane;
  logic [FW-1:0]        tm_wdata;
  sge_pkg::travel_row_t tm_rdata;

  // per cell datapath
  logic                 item_fire, ld_ok, active, last_cell, adv, post;
  logic [CELL_W-1:0]    ld_cell, nb_addr;
  logic [7:0]           nb_ok;
  logic                 up_ok, dn_ok, lf_ok, rt_ok;
  logic [2:0]           rd_d, pd_d;
  logic [sge_pkg::PROD_W-1:0] prod;
  logic [SW-1:0]        tot;
  logic [FW-1:0]        s_q, i_q, r_q;
  logic [PW-1:0]        pop_q;
  logic [ACC_W-1:0]     acc_i, acc_s, acc_r;
  sge_pkg::upd_ctl_t    upd_ctl;
  sge_pkg::cell_word_t  new_word;
  logic [PW-1:0]        wt_i, wt_s, wt_r;
  logic [FW-1:0]        ld_inf;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows     <= '0;
      grid_cols     <= '0;
      rows_full     <= 1'b1;
      cols_full     <= 1'b1;
      virulence     <= '0;
      recovery_rate <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (sge_pkg::cfg_reg_t'(cfg_index))
        sge_pkg::REG_ROWS: begin
          grid_rows <= cfg_data[6:0];
          rows_full <= 1'b0;
        end
        sge_pkg::REG_COLS: begin
          grid_cols <= cfg_data[6:0];
          cols_full <= 1'b0;
        end
        sge_pkg::REG_VIRULENCE: virulence <= cfg_data;
        sge_pkg::REG_RECOVERY: recovery_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // active grid size, clamped to 1..max
  always_comb begin
    if (rows_full || DIM_W'(grid_rows) > DIM_W'(MAX_ROWS)) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end else if (grid_rows == 7'd0) begin
      rows_eff = DIM_W'(1);
    end else begin
      rows_eff = DIM_W'(grid_rows);
    end
    if (cols_full || DIM_W'(grid_cols) > DIM_W'(MAX_COLS)) begin
      cols_eff = DIM_W'(MAX_COLS);
    end else if (grid_cols == 7'd0) begin
      cols_eff = DIM_W'(1);
    end else begin
      cols_eff = DIM_W'(grid_cols);
    end
  end

  // load decode
  assign item_fire = item_valid && item_ready;
  assign ld_ok     = (DIM_W'(item.row) < DIM_W'(MAX_ROWS)) &&
                     (DIM_W'(item.col) < DIM_W'(MAX_COLS));
  assign ld_cell   = CELL_W'(32'(item.row) * MAX_COLS + 32'(item.col));
  assign ld_inf    = sge_pkg::clamp_one(item.infected_share);

  // stencil position flags
  assign active    = (DIM_W'(r_cnt) < rows_eff) && (DIM_W'(c_cnt) < cols_eff);
  assign up_ok     = (r_cnt != '0);
  assign dn_ok     = (DIM_W'(r_cnt) + DIM_W'(1) < rows_eff);
  assign lf_ok     = (c_cnt != '0);
  assign rt_ok     = (DIM_W'(c_cnt) + DIM_W'(1) < cols_eff);
  assign nb_ok     = {dn_ok & rt_ok, dn_ok, dn_ok & lf_ok, rt_ok,
                      lf_ok, up_ok & rt_ok, up_ok, up_ok & lf_ok};
  assign rd_d      = 3'(ph - PH_W'(1));
  assign pd_d      = 3'(ph - PH_W'(2));
  assign last_cell = (cell_idx == CELL_W'(CELLS - 1));
  assign adv       = (state == sge_pkg::ST_CELL) &&
                     (active ? (ph == PH_LAST) : (ph == PH_W'(1)));
  assign post      = (state == sge_pkg::ST_DONE) && (!result_valid || result_ready);

  // neighbour address, own cell when off the grid
  always_comb begin
    int off;
    off = 0;
    case (rd_d)
      3'd0: off = -MAX_COLS - 1;
      3'd1: off = -MAX_COLS;
      3'd2: off = -MAX_COLS + 1;
      3'd3: off = -1;
      3'd4: off = 1;
      3'd5: off = MAX_COLS - 1;
      3'd6: off = MAX_COLS;
      3'd7: off = MAX_COLS + 1;
      default: off = 0;
    endcase
    nb_addr = nb_ok[rd_d] ? CELL_W'(32'(cell_idx) + off) : cell_idx;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sge_pkg::ST_CLEAR: if (last_cell) state_next = sge_pkg::ST_IDLE;
      sge_pkg::ST_IDLE: begin
        if (item_fire && item.action == sge_pkg::ACT_STEP) begin
          state_next = sge_pkg::ST_CELL;
        end
      end
      sge_pkg::ST_CELL: if (adv && last_cell) state_next = sge_pkg::ST_DONE;
      sge_pkg::ST_DONE: if (post) state_next = sge_pkg::ST_IDLE;
      default: state_next = sge_pkg::ST_CLEAR;
    endcase
  end

  // memory control and strobes
  always_comb begin
    item_ready       = 1'b0;
    cm_we            = 1'b0;
    cm_wbank         = ~bank;
    cm_waddr         = cell_idx;
    cm_wdata         = cm_rdata;
    cm_raddr         = cell_idx;
    tm_clr           = 1'b0;
    tm_we            = 1'b0;
    tm_waddr         = ld_cell;
    tm_lane          = item.neighbour;
    tm_wdata         = sge_pkg::clamp_one(item.travel_prob);
    upd_ctl          = '0;
    case (state)
      sge_pkg::ST_CLEAR: begin
        cm_we    = 1'b1;
        cm_wbank = 1'b0;
        cm_wdata = '0;
        tm_clr   = 1'b1;
        tm_waddr = cell_idx;
      end
      sge_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cm_wbank   = bank;
        cm_waddr   = ld_cell;
        cm_wdata   = '{pop: item.population, s: sge_pkg::ONE - ld_inf,
                       i: ld_inf, r: '0};
        if (item_fire && ld_ok) begin
          cm_we = (item.action == sge_pkg::ACT_LOAD_CELL);
          tm_we = (item.action == sge_pkg::ACT_LOAD_TRAVEL);
        end
      end
      sge_pkg::ST_CELL: begin
        if (ph != '0 && ph <= PH_W'(8)) cm_raddr = nb_addr;
        if (active) begin
          cm_we            = (ph == PH_W'(12));
          cm_wdata         = new_word;
          upd_ctl.mul_rate = (ph == PH_W'(2));
          upd_ctl.mul_inf  = (ph == PH_W'(11));
          upd_ctl.hold_new = (ph == PH_W'(12));
          upd_ctl.mul_wt   = (ph == PH_W'(13));
        end else begin
          // cells outside the active area carry over to the new bank
          cm_we = (ph == PH_W'(1));
        end
      end
      sge_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // cell store, two banks by generation parity
  always_ff @(posedge clk) begin
    if (cm_we) cell_mem[cm_wbank][cm_waddr] <= cm_wdata;
    cm_rdata <= cell_mem[bank][cm_raddr];
  end

  // travel store, one row of eight probabilities per cell
  always_ff @(posedge clk) begin
    if (tm_clr) begin
      travel_mem[tm_waddr] <= '0;
    end else if (tm_we) begin
      travel_mem[tm_waddr][tm_lane] <= tm_wdata;
    end
    tm_rdata <= travel_mem[cell_idx];
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sge_pkg::ST_CLEAR;
      ph           <= '0;
      cell_idx     <= '0;
      r_cnt        <= '0;
      c_cnt        <= '0;
      bank         <= 1'b0;
      generation   <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        sge_pkg::ST_CLEAR: cell_idx <= last_cell ? '0 : cell_idx + CELL_W'(1);
        sge_pkg::ST_IDLE: begin
          ph       <= '0;
          cell_idx <= '0;
          r_cnt    <= '0;
          c_cnt    <= '0;
        end
        sge_pkg::ST_CELL: begin
          if (adv) begin
            ph       <= '0;
            cell_idx <= last_cell ? '0 : cell_idx + CELL_W'(1);
            if (c_cnt == COL_W'(MAX_COLS - 1)) begin
              c_cnt <= '0;
              r_cnt <= r_cnt + ROW_W'(1);
            end else begin
              c_cnt <= c_cnt + COL_W'(1);
            end
          end else begin
            ph <= ph + PH_W'(1);
          end
        end
        default: ;
      endcase
      if (post) begin
        bank         <= ~bank;
        generation   <= generation + 32'd1;
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // stencil gather and accumulation
  always_ff @(posedge clk) begin
    if (state == sge_pkg::ST_IDLE) begin
      acc_i <= '0;
      acc_s <= '0;
      acc_r <= '0;
    end
    if (state == sge_pkg::ST_CELL) begin
      if (ph == '0) tot <= '0;
      if (ph == PH_W'(1)) begin
        s_q   <= cm_rdata.s;
        i_q   <= cm_rdata.i;
        r_q   <= cm_rdata.r;
        pop_q <= cm_rdata.pop;
      end
      if (ph >= PH_W'(2) && ph <= PH_W'(9)) begin
        prod <= nb_ok[pd_d] ? sge_pkg::PROD_W'(cm_rdata.i * tm_rdata[pd_d]) : '0;
      end
      if (ph >= PH_W'(3) && ph <= PH_W'(10)) begin
        tot <= tot + SW'(prod >> FB);
      end
      if (active && ph == PH_LAST) begin
        acc_i <= acc_i + ACC_W'(wt_i);
        acc_s <= acc_s + ACC_W'(wt_s);
        acc_r <= acc_r + ACC_W'(wt_r);
      end
    end
  end

  // result register with saturated totals
  always_ff @(posedge clk) begin
    if (post) begin
      result.total_infected    <= (|acc_i[ACC_W-1:32]) ? '1 : acc_i[31:0];
      result.total_susceptible <= (|acc_s[ACC_W-1:32]) ? '1 : acc_s[31:0];
      result.total_removed     <= (|acc_r[ACC_W-1:32]) ? '1 : acc_r[31:0];
      result.generation        <= generation + 32'd1;
    end
  end

  sge_cell_update u_update (
    .clk           (clk),
    .ctl           (upd_ctl),
    .virulence     (virulence),
    .recovery_rate (recovery_rate),
    .s             (s_q),
    .i             (i_q),
    .r             (r_q),
    .pop           (pop_q),
    .tot           (tot),
    .new_word      (new_word),
    .wt_i          (wt_i),
    .wt_s          (wt_s),
    .wt_r          (wt_r)
  );

`ifndef ASSERT_OFF
  // a step never writes the bank it is reading
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (state == sge_pkg::ST_CELL && cm_we) |-> (cm_wbank != bank))
    else $error("step write hit the read bank");

  // phase counter stays within the cell schedule
  a_ph_range: assert property (@(posedge clk) disable iff (rst)
    (state == sge_pkg::ST_CELL) |-> (ph <= PH_LAST))
    else $error("cell phase out of range");

  // a result appears only when a step finishes
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == sge_pkg::ST_DONE))
    else $error("result without finished step");

  // bank flips together with the generation count
  a_bank_gen: assert property (@(posedge clk) disable iff (rst)
    (generation != $past(generation)) |-> (bank != $past(bank)))
    else $error("bank and generation out of step");
`endif

endmodule

@@ rtl/core/sge_cell_update.sv @@
// sge_cell_update: arithmetic of one cell generation, pipelined by strobes
// infection, recovery, saturation and population-weighted terms
// depends on sge_pkg
`timescale 1ns / 1ps

module sge_cell_update (
  input  logic                         clk,
  input  sge_pkg::upd_ctl_t            ctl,
  input  logic [sge_pkg::FRAC_W-1:0]   virulence,
  input  logic [sge_pkg::FRAC_W-1:0]   recovery_rate,
  input  logic [sge_pkg::FRAC_W-1:0]   s,
  input  logic [sge_pkg::FRAC_W-1:0]   i,
  input  logic [sge_pkg::FRAC_W-1:0]   r,
  input  logic [sge_pkg::POP_W-1:0]    pop,
  input  logic [sge_pkg::SUM_W-1:0]    tot,
  output sge_pkg::cell_word_t          new_word,
  output logic [sge_pkg::POP_W-1:0]    wt_i,
  output logic [sge_pkg::POP_W-1:0]    wt_s,
  output logic [sge_pkg::POP_W-1:0]    wt_r
);

  localparam int FW   = sge_pkg::FRAC_W;
  localparam int FB   = sge_pkg::FRAC_BITS;
  localparam int PW   = sge_pkg::POP_W;
  localparam int SW   = sge_pkg::SUM_W;
  localparam int M2_W = SW + 1;
  localparam int INF_W = M2_W + 1;
  localparam int DW   = INF_W + 2;

  logic [FW-1:0]        vs;
  logic [FW-1:0]        rec;
  logic [FW-1:0]        m1;
  logic [M2_W-1:0]      m2;
  logic [INF_W-1:0]     inf;
  logic signed [DW-1:0] s_dif;
  logic signed [DW-1:0] i_dif;
  logic signed [DW-1:0] r_sum;
  sge_pkg::cell_word_t  nw_q;

  function automatic logic [FW-1:0] sat_frac(input logic signed [DW-1:0] x);
    if (x < 0) begin
      sat_frac = '0;
    end else if (x > $signed(DW'(sge_pkg::ONE))) begin
      sat_frac = sge_pkg::ONE;
    end else begin
      sat_frac = x[FW-1:0];
    end
  endfunction

  // rate products, one multiplier each
  always_ff @(posedge clk) begin
    if (ctl.mul_rate) begin
      vs  <= FW'((2*FW)'(virulence * s) >> FB);
      rec <= FW'((2*FW)'(recovery_rate * i) >> FB);
    end
  end

  // infection terms from local and neighbour infected
  always_ff @(posedge clk) begin
    if (ctl.mul_inf) begin
      m1 <= FW'((2*FW)'(vs * i) >> FB);
      m2 <= M2_W'((FW+SW)'(vs * tot) >> FB);
    end
  end

  // saturated new fractions
  always_comb begin
    inf   = INF_W'(m1) + INF_W'(m2);
    s_dif = $signed(DW'(s)) - $signed(DW'(inf));
    i_dif = $signed(DW'(i)) + $signed(DW'(inf)) - $signed(DW'(rec));
    r_sum = $signed(DW'(r)) + $signed(DW'(rec));
    new_word.pop = pop;
    new_word.s   = sat_frac(s_dif);
    new_word.i   = sat_frac(i_dif);
    new_word.r   = sat_frac(r_sum);
  end

  always_ff @(posedge clk) begin
    if (ctl.hold_new) begin
      nw_q <= new_word;
    end
  end

  // population-weighted terms for the totals
  always_ff @(posedge clk) begin
    if (ctl.mul_wt) begin
      wt_i <= PW'((FW+PW)'(nw_q.i * nw_q.pop) >> FB);
      wt_s <= PW'((FW+PW)'(nw_q.s * nw_q.pop) >> FB);
      wt_r <= PW'((FW+PW)'(nw_q.r * nw_q.pop) >> FB);
    end
  end

endmodule
